/* rtl/mps_pkg.sv */
// ----------------------------------------------------------------------------
// Modem power-up sequencer package
// Shared types, register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int TIME_BITS_DEF = 32;

    // Register reset values.
    localparam logic        GPRS_WANTED_RST      = 1'b0;
    localparam logic [15:0] SETTLE_WAIT_RST      = 16'd2500;
    localparam logic [15:0] POWER_PULSE_RST      = 16'd2000;
    localparam logic [15:0] RESET_PULSE_RST      = 16'd100;
    localparam logic [15:0] REG_TIMEOUT_RST      = 16'd20000;
    localparam logic [15:0] POLL_INTERVAL_RST    = 16'd2000;
    localparam logic [1:0]  MAX_POWER_TRIES_RST  = 2'd2;

    // Power-try counter saturates here.
    localparam logic [1:0]  POWER_TRIES_MAX      = 2'd3;

    typedef enum logic [2:0] {
        CFG_GPRS_WANTED     = 3'd0,
        CFG_SETTLE_WAIT     = 3'd1,
        CFG_POWER_PULSE     = 3'd2,
        CFG_RESET_PULSE     = 3'd3,
        CFG_REG_TIMEOUT     = 3'd4,
        CFG_POLL_INTERVAL   = 3'd5,
        CFG_MAX_POWER_TRIES = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_WAIT  = 4'd1,
        PH_PWR   = 4'd2,
        PH_RST   = 4'd3,
        PH_CHECK = 4'd4,
        PH_START = 4'd5,
        PH_SIM   = 4'd6,
        PH_REG   = 4'd7,
        PH_BATT  = 4'd8,
        PH_GPRS  = 4'd9,
        PH_RUN   = 4'd10,
        PH_ERR   = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        Q_NONE      = 3'd0,
        Q_START     = 3'd1,
        Q_PIN       = 3'd2,
        Q_NETSTAT   = 3'd3,
        Q_BATTERY   = 3'd4,
        Q_GPRS_ON   = 3'd5,
        Q_SIGNAL    = 3'd6,
        Q_GPRS_STAT = 3'd7
    } t_query;

    localparam logic [1:0] POLL_SIGNAL = 2'd0;
    localparam logic [1:0] POLL_DATA   = 2'd1;
    localparam logic [1:0] POLL_SKIP   = 2'd2;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               enabled;
        logic               module_ready;
        logic               module_powered;
        logic               start_ok;
        logic               sim_ok;
        logic               net_registered;
        logic               data_enable_ok;
        logic signed [7:0]  signal_sample;
        logic               data_active_sample;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         state_code;
        logic               is_running;
        logic               power_key_low;
        logic               reset_line_low;
        logic               flush_serial;
        logic [2:0]         query;
        logic signed [7:0]  signal_level;
        logic               data_active;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic        gprs_wanted;
        logic [15:0] settle_wait_ms;
        logic [15:0] power_pulse_ms;
        logic [15:0] reset_pulse_ms;
        logic [15:0] register_timeout_ms;
        logic [15:0] poll_interval_ms;
        logic [1:0]  max_power_tries;
    } t_cfg;

    // Sequencer state other than the time mark, whose width is a parameter.
    typedef struct packed {
        t_phase             phase;
        t_phase             pending_phase;
        logic [1:0]         power_tries;
        logic [1:0]         poll_slot;
        logic signed [7:0]  signal_hold;
        logic               data_hold;
        logic               key_low_hold;
        logic               rst_low_hold;
    } t_state;

endpackage

/* rtl/mps_stream_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel carrying a payload of type T; a transaction completes when
// valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface mps_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration register bank
// Holds the sequencer's timing and retry settings, written over a
// valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module mps_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mps_stream_if.sink     i_cfg,
    output mps_pkg::t_cfg  o_cfg
);
    import mps_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gprs_wanted         <= GPRS_WANTED_RST;
            r_cfg.settle_wait_ms      <= SETTLE_WAIT_RST;
            r_cfg.power_pulse_ms      <= POWER_PULSE_RST;
            r_cfg.reset_pulse_ms      <= RESET_PULSE_RST;
            r_cfg.register_timeout_ms <= REG_TIMEOUT_RST;
            r_cfg.poll_interval_ms    <= POLL_INTERVAL_RST;
            r_cfg.max_power_tries     <= MAX_POWER_TRIES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_GPRS_WANTED:     r_cfg.gprs_wanted         <= i_cfg.data.value[0];
                CFG_SETTLE_WAIT:     r_cfg.settle_wait_ms      <= i_cfg.data.value;
                CFG_POWER_PULSE:     r_cfg.power_pulse_ms      <= i_cfg.data.value;
                CFG_RESET_PULSE:     r_cfg.reset_pulse_ms      <= i_cfg.data.value;
                CFG_REG_TIMEOUT:     r_cfg.register_timeout_ms <= i_cfg.data.value;
                CFG_POLL_INTERVAL:   r_cfg.poll_interval_ms    <= i_cfg.data.value;
                CFG_MAX_POWER_TRIES: r_cfg.max_power_tries     <= i_cfg.data.value[1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mps_step.sv */
// ----------------------------------------------------------------------------
// Sequencer step logic
// Next-state and result computation for one scheduler tick.
// ----------------------------------------------------------------------------
module mps_step #(
    parameter int TIME_BITS = mps_pkg::TIME_BITS_DEF
) (
    input  mps_pkg::t_cfg       i_cfg,
    input  mps_pkg::t_in_item   i_item,
    input  mps_pkg::t_state     i_state,
    input  logic [TIME_BITS-1:0] i_mark,
    output mps_pkg::t_state     o_state,
    output logic [TIME_BITS-1:0] o_mark,
    output mps_pkg::t_out_item  o_result
);
    import mps_pkg::*;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_settle_done;
    logic                 w_power_done;
    logic                 w_reset_done;
    logic                 w_reg_late;
    logic                 w_poll_due;
    logic [1:0]           w_tries_inc;
    t_state               n_state;
    logic [TIME_BITS-1:0] n_mark;
    logic                 n_flush;
    t_query               n_query;

    assign w_now     = TIME_BITS'(i_item.now_ms);
    assign w_elapsed = w_now - i_mark;

    assign w_settle_done = w_elapsed >= TIME_BITS'(i_cfg.settle_wait_ms);
    assign w_power_done  = w_elapsed >= TIME_BITS'(i_cfg.power_pulse_ms);
    assign w_reset_done  = w_elapsed >= TIME_BITS'(i_cfg.reset_pulse_ms);
    assign w_poll_due    = w_elapsed >= TIME_BITS'(i_cfg.poll_interval_ms);
    // A successful registration restarts the time mark before the timeout
    // check, so only a zero timeout can expire in that case.
    assign w_reg_late    = i_item.net_registered ? (i_cfg.register_timeout_ms == 16'd0)
                         : (w_elapsed >= TIME_BITS'(i_cfg.register_timeout_ms));

    assign w_tries_inc = (i_state.power_tries == POWER_TRIES_MAX)
                       ? POWER_TRIES_MAX : i_state.power_tries + 2'd1;

    always_comb begin
        n_state = i_state;
        n_mark  = i_mark;
        n_flush = 1'b0;
        n_query = Q_NONE;

        // Disabling forces idle; idle is then processed in the same tick.
        if (!i_item.enabled) begin
            n_flush               = 1'b1;
            n_state.key_low_hold  = 1'b0;
            n_state.rst_low_hold  = 1'b0;
            n_state.phase         = PH_IDLE;
        end

        case (n_state.phase)
            PH_IDLE: begin
                if (i_item.module_ready) begin
                    n_state.pending_phase = PH_PWR;
                    n_mark                = w_now;
                    n_state.phase         = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (w_settle_done) begin
                    case (i_state.pending_phase)
                        PH_PWR: begin
                            n_state.power_tries  = w_tries_inc;
                            n_state.key_low_hold = 1'b1;
                            n_mark               = w_now;
                            n_state.phase        = PH_PWR;
                        end
                        PH_RST: begin
                            n_state.rst_low_hold = 1'b1;
                            n_mark               = w_now;
                            n_state.phase        = PH_RST;
                        end
                        PH_CHECK, PH_START, PH_SIM, PH_GPRS: begin
                            n_state.phase = i_state.pending_phase;
                        end
                        PH_BATT, PH_RUN: begin
                            n_mark        = w_now;
                            n_state.phase = i_state.pending_phase;
                        end
                        default: begin
                            n_flush              = 1'b1;
                            n_state.key_low_hold = 1'b0;
                            n_state.rst_low_hold = 1'b0;
                            n_state.phase        = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_PWR: begin
                if (w_power_done) begin
                    n_state.key_low_hold  = 1'b0;
                    n_state.pending_phase = PH_CHECK;
                    n_mark                = w_now;
                    n_state.phase         = PH_WAIT;
                end
            end
            PH_RST: begin
                if (w_reset_done) begin
                    n_state.rst_low_hold  = 1'b0;
                    n_state.pending_phase = PH_START;
                    n_mark                = w_now;
                    n_state.phase         = PH_WAIT;
                end
            end
            PH_CHECK: begin
                if (i_item.module_powered) begin
                    n_state.rst_low_hold = 1'b1;
                    n_mark               = w_now;
                    n_state.phase        = PH_RST;
                end else if (i_state.power_tries < i_cfg.max_power_tries) begin
                    n_state.power_tries  = w_tries_inc;
                    n_state.key_low_hold = 1'b1;
                    n_mark               = w_now;
                    n_state.phase        = PH_PWR;
                end else begin
                    n_state.phase = PH_ERR;
                end
            end
            PH_START: begin
                n_query = Q_START;
                if (i_item.start_ok) begin
                    n_state.pending_phase = PH_SIM;
                    n_mark                = w_now;
                    n_state.phase         = PH_WAIT;
                end else begin
                    n_state.phase = PH_ERR;
                end
            end
            PH_SIM: begin
                n_query = Q_PIN;
                if (i_item.sim_ok) begin
                    n_mark        = w_now;
                    n_state.phase = PH_REG;
                end else begin
                    n_state.phase = PH_ERR;
                end
            end
            PH_REG: begin
                n_query = Q_NETSTAT;
                if (i_item.net_registered) begin
                    n_state.pending_phase = PH_BATT;
                    n_mark                = w_now;
                    n_state.phase         = PH_WAIT;
                end
                if (w_reg_late) begin
                    n_state.phase = PH_ERR;
                end
            end
            PH_BATT: begin
                n_query = Q_BATTERY;
                n_mark  = w_now;
                if (i_cfg.gprs_wanted) begin
                    n_state.pending_phase = PH_GPRS;
                    n_state.phase         = PH_WAIT;
                end else begin
                    n_state.phase = PH_RUN;
                end
            end
            PH_GPRS: begin
                n_query = Q_GPRS_ON;
                if (i_item.data_enable_ok) begin
                    n_mark        = w_now;
                    n_state.phase = PH_RUN;
                end else begin
                    n_state.phase = PH_ERR;
                end
            end
            PH_RUN: begin
                if (w_poll_due) begin
                    n_mark = w_now;
                    case (i_state.poll_slot)
                        POLL_SIGNAL: begin
                            n_state.signal_hold = i_item.signal_sample;
                            n_query             = Q_SIGNAL;
                            n_state.poll_slot   = POLL_DATA;
                        end
                        POLL_DATA: begin
                            n_state.data_hold = i_item.data_active_sample;
                            n_query           = Q_GPRS_STAT;
                            n_state.poll_slot = POLL_SKIP;
                        end
                        POLL_SKIP: n_state.poll_slot = POLL_SIGNAL;
                        default:   n_state.poll_slot = POLL_DATA;
                    endcase
                end
            end
            PH_ERR: begin
                n_state.signal_hold = 8'sd0;
                n_state.data_hold   = 1'b0;
            end
            default: begin
                n_flush              = 1'b1;
                n_state.key_low_hold = 1'b0;
                n_state.rst_low_hold = 1'b0;
                n_state.phase        = PH_IDLE;
            end
        endcase
    end

    assign o_state = n_state;
    assign o_mark  = n_mark;

    assign o_result.state_code     = n_state.phase;
    assign o_result.is_running     = (n_state.phase == PH_RUN);
    assign o_result.power_key_low  = n_state.key_low_hold;
    assign o_result.reset_line_low = n_state.rst_low_hold;
    assign o_result.flush_serial   = n_flush;
    assign o_result.query          = n_query;
    assign o_result.signal_level   = n_state.signal_hold;
    assign o_result.data_active    = n_state.data_hold;

endmodule

/* rtl/modem_power_up_sequencer.sv */
// An accepted input is held in the input register and its result is then
// registered in the result register. Throughput: one transaction per cycle
// unless the result channel stalls; the state update is one step-logic pass.
// Reset: synchronous, active low; the sequencer returns to idle with all
// holds and counters cleared and the configuration registers at defaults.
// ----------------------------------------------------------------------------
// Modem power-up sequencer
// Walks the modem power-up sequence one scheduler tick per transaction and
// reports the state, pin drives, issued query and polled values.
// ----------------------------------------------------------------------------
module modem_power_up_sequencer #(
    parameter int TIME_BITS = mps_pkg::TIME_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mps_stream_if.sink    i_in,
    mps_stream_if.source  o_out,
    mps_stream_if.sink    i_cfg
);
    import mps_pkg::*;

    t_cfg                 w_cfg;
    logic                 w_adv;
    t_state               w_next_state;
    logic [TIME_BITS-1:0] w_next_mark;
    t_out_item            w_result;

    logic                 r_in_valid;
    t_in_item             r_in;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_state               r_state;
    logic [TIME_BITS-1:0] r_mark;

    mps_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    mps_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .i_state  (r_state),
        .i_mark   (r_mark),
        .o_state  (w_next_state),
        .o_mark   (w_next_mark),
        .o_result (w_result)
    );

    // The held item advances when the result register is free or draining.
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.phase         <= PH_IDLE;
            r_state.pending_phase <= PH_IDLE;
            r_state.power_tries   <= 2'd0;
            r_state.poll_slot     <= POLL_SIGNAL;
            r_state.signal_hold   <= 8'sd0;
            r_state.data_hold     <= 1'b0;
            r_state.key_low_hold  <= 1'b0;
            r_state.rst_low_hold  <= 1'b0;
            r_mark                <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= w_next_state;
                r_mark      <= w_next_mark;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

endmodule

/* verif/mps_sequencer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modem power-up sequencer checker
// Watches the tick, result and register channels, keeps its own model of the
// sequencer and compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module mps_sequencer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mps_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mps_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  mps_pkg::t_cfg_item i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import mps_pkg::*;

    t_cfg              cfg;
    t_phase            phase;
    t_phase            pending_step;
    logic [31:0]       mark_ms;
    logic [1:0]        power_tries;
    logic [1:0]        poll_slot;
    logic signed [7:0] signal_hold;
    logic              data_hold;
    logic              key_low;
    logic              rst_low;
    logic              flush;

    t_out_item         expected_results[$];
    t_out_item         oldest;
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    initial o_pending = 0;

    function automatic void enter_idle();
        flush   = 1'b1;
        key_low = 1'b0;
        rst_low = 1'b0;
        phase   = PH_IDLE;
    endfunction

    function automatic void enter_settle(t_phase next, logic [31:0] now);
        pending_step = next;
        mark_ms      = now;
        phase        = PH_WAIT;
    endfunction

    function automatic void start_power_pulse(logic [31:0] now);
        if (power_tries < POWER_TRIES_MAX) power_tries = power_tries + 2'd1;
        key_low = 1'b1;
        mark_ms = now;
        phase   = PH_PWR;
    endfunction

    function automatic void start_reset_pulse(logic [31:0] now);
        rst_low = 1'b1;
        mark_ms = now;
        phase   = PH_RST;
    endfunction

    function automatic void enter_running(logic [31:0] now);
        mark_ms = now;
        phase   = PH_RUN;
    endfunction

    // One scheduler tick of the sequencer; returns the outputs of that tick.
    function automatic t_out_item predict_tick(t_in_item tick);
        t_out_item   res;
        logic [31:0] elapsed;
        t_query      q;
        q     = Q_NONE;
        flush = 1'b0;
        if (!tick.enabled) enter_idle();
        elapsed = tick.now_ms - mark_ms;
        case (phase)
            PH_IDLE: begin
                if (tick.module_ready) enter_settle(PH_PWR, tick.now_ms);
            end
            PH_WAIT: begin
                if (elapsed >= {16'd0, cfg.settle_wait_ms}) begin
                    case (pending_step)
                        PH_PWR:   start_power_pulse(tick.now_ms);
                        PH_RST:   start_reset_pulse(tick.now_ms);
                        PH_CHECK: phase = PH_CHECK;
                        PH_START: phase = PH_START;
                        PH_SIM:   phase = PH_SIM;
                        PH_BATT: begin
                            mark_ms = tick.now_ms;
                            phase   = PH_BATT;
                        end
                        PH_GPRS:  phase = PH_GPRS;
                        PH_RUN:   enter_running(tick.now_ms);
                        default:  enter_idle();
                    endcase
                end
            end
            PH_PWR: begin
                if (elapsed >= {16'd0, cfg.power_pulse_ms}) begin
                    key_low = 1'b0;
                    enter_settle(PH_CHECK, tick.now_ms);
                end
            end
            PH_RST: begin
                if (elapsed >= {16'd0, cfg.reset_pulse_ms}) begin
                    rst_low = 1'b0;
                    enter_settle(PH_START, tick.now_ms);
                end
            end
            PH_CHECK: begin
                if (tick.module_powered) start_reset_pulse(tick.now_ms);
                else if (power_tries < cfg.max_power_tries) start_power_pulse(tick.now_ms);
                else phase = PH_ERR;
            end
            PH_START: begin
                q = Q_START;
                if (tick.start_ok) enter_settle(PH_SIM, tick.now_ms);
                else phase = PH_ERR;
            end
            PH_SIM: begin
                q = Q_PIN;
                if (tick.sim_ok) begin
                    mark_ms = tick.now_ms;
                    phase   = PH_REG;
                end else begin
                    phase = PH_ERR;
                end
            end
            PH_REG: begin
                q = Q_NETSTAT;
                if (tick.net_registered) enter_settle(PH_BATT, tick.now_ms);
                // The timeout is judged against the mark as it stands after a
                // success, so it overrides a successful registration.
                if (tick.now_ms - mark_ms >= {16'd0, cfg.register_timeout_ms}) phase = PH_ERR;
            end
            PH_BATT: begin
                q = Q_BATTERY;
                if (cfg.gprs_wanted) enter_settle(PH_GPRS, tick.now_ms);
                else enter_running(tick.now_ms);
            end
            PH_GPRS: begin
                q = Q_GPRS_ON;
                if (tick.data_enable_ok) enter_running(tick.now_ms);
                else phase = PH_ERR;
            end
            PH_RUN: begin
                if (elapsed >= {16'd0, cfg.poll_interval_ms}) begin
                    case (poll_slot)
                        POLL_SIGNAL: begin
                            signal_hold = tick.signal_sample;
                            q           = Q_SIGNAL;
                        end
                        POLL_DATA: begin
                            data_hold = tick.data_active_sample;
                            q         = Q_GPRS_STAT;
                        end
                        default: ;
                    endcase
                    poll_slot = 2'((int'(poll_slot) + 1) % 3);
                    mark_ms   = tick.now_ms;
                end
            end
            PH_ERR: begin
                signal_hold = '0;
                data_hold   = 1'b0;
            end
            default: enter_idle();
        endcase
        res.state_code     = phase;
        res.is_running     = (phase == PH_RUN);
        res.power_key_low  = key_low;
        res.reset_line_low = rst_low;
        res.flush_serial   = flush;
        res.query          = q;
        res.signal_level   = signal_hold;
        res.data_active    = data_hold;
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.gprs_wanted         = GPRS_WANTED_RST;
            cfg.settle_wait_ms      = SETTLE_WAIT_RST;
            cfg.power_pulse_ms      = POWER_PULSE_RST;
            cfg.reset_pulse_ms      = RESET_PULSE_RST;
            cfg.register_timeout_ms = REG_TIMEOUT_RST;
            cfg.poll_interval_ms    = POLL_INTERVAL_RST;
            cfg.max_power_tries     = MAX_POWER_TRIES_RST;
            phase        = PH_IDLE;
            pending_step = PH_IDLE;
            mark_ms      = '0;
            power_tries  = '0;
            poll_slot    = POLL_SIGNAL;
            signal_hold  = '0;
            data_hold    = 1'b0;
            key_low      = 1'b0;
            rst_low      = 1'b0;
            flush        = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_GPRS_WANTED:     cfg.gprs_wanted         = i_cfg_data.value[0];
                    CFG_SETTLE_WAIT:     cfg.settle_wait_ms      = i_cfg_data.value;
                    CFG_POWER_PULSE:     cfg.power_pulse_ms      = i_cfg_data.value;
                    CFG_RESET_PULSE:     cfg.reset_pulse_ms      = i_cfg_data.value;
                    CFG_REG_TIMEOUT:     cfg.register_timeout_ms = i_cfg_data.value;
                    CFG_POLL_INTERVAL:   cfg.poll_interval_ms    = i_cfg_data.value;
                    CFG_MAX_POWER_TRIES: cfg.max_power_tries     = i_cfg_data.value[1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result transaction with no prediction waiting");
                    fail_total++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("state_code", oldest.state_code, i_out_data.state_code);
                    check_field("is_running", oldest.is_running, i_out_data.is_running);
                    check_field("power_key_low", oldest.power_key_low,
                                i_out_data.power_key_low);
                    check_field("reset_line_low", oldest.reset_line_low,
                                i_out_data.reset_line_low);
                    check_field("flush_serial", oldest.flush_serial,
                                i_out_data.flush_serial);
                    check_field("query", oldest.query, i_out_data.query);
                    check_field("signal_level", int'(oldest.signal_level),
                                int'(i_out_data.signal_level));
                    check_field("data_active", oldest.data_active, i_out_data.data_active);
                end
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(predict_tick(i_in_data));
        end
        o_pending <= expected_results.size();
    end

endmodule

/* verif/modem_power_up_sequencer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modem power-up sequencer testbench
// Drives scheduler ticks through a directed walk of the power-up sequence and
// then through phases of random ticks under several register settings, with
// random gaps on the tick channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module modem_power_up_sequencer_tb;
    import mps_pkg::*;

    localparam int         HALF_PERIOD     = 4;
    localparam int         RESET_CYCLES    = 10;
    localparam int         LIMIT_CYCLES    = 400000;
    localparam int         DRAIN_CYCLES    = 6;
    localparam int         PHASE_COUNT     = 10;
    localparam int         TICKS_PER_PHASE = 105;
    localparam int         IDLE_MAX        = 6;
    localparam logic [2:0] CFG_UNUSED_IDX  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;

    logic [31:0] now_cursor;
    int          step_max;
    int          send_burst;

    mps_stream_if #(.T(t_in_item))  in_ch  ();
    mps_stream_if #(.T(t_out_item)) out_ch ();
    mps_stream_if #(.T(t_cfg_item)) cfg_ch ();

    modem_power_up_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mps_sequencer_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls with occasional stretches of none.
    initial begin
        int stall;
        int burst;
        out_ch.ready = 1'b0;
        burst = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (burst > 0) begin
                burst--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
                stall = $urandom_range(0, IDLE_MAX);
            end
            repeat (stall) @(negedge i_clk) out_ch.ready <= 1'b0;
            @(negedge i_clk) out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_tick(t_in_item tick);
        int gap;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 40);
            gap = $urandom_range(0, IDLE_MAX);
        end
        repeat (gap) @(negedge i_clk) in_ch.valid <= 1'b0;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= tick;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Flags are {enabled, ready, powered, start_ok, sim_ok, registered, gprs_ok}.
    task automatic send_flags(logic [31:0] now, logic [6:0] flags,
                              logic signed [7:0] sig, logic act);
        t_in_item tick;
        tick.now_ms             = now;
        {tick.enabled, tick.module_ready, tick.module_powered, tick.start_ok,
         tick.sim_ok, tick.net_registered, tick.data_enable_ok} = flags;
        tick.signal_sample      = sig;
        tick.data_active_sample = act;
        send_tick(tick);
    endtask

    // Mostly cooperative modem answers so the sequence gets deep; a tenth of
    // the ticks carry arbitrary answers.
    function automatic t_in_item random_tick();
        t_in_item tick;
        logic     noise;
        now_cursor = now_cursor + 32'($urandom_range(0, step_max));
        if ($urandom_range(0, 49) == 0) now_cursor = now_cursor + $urandom();
        noise = ($urandom_range(0, 9) == 0);
        tick.now_ms             = now_cursor;
        tick.enabled            = noise ? 1'($urandom()) : ($urandom_range(0, 99) >= 3);
        tick.module_ready       = noise ? 1'($urandom()) : ($urandom_range(0, 99) >= 5);
        tick.module_powered     = noise ? 1'($urandom()) : ($urandom_range(0, 99) >= 25);
        tick.start_ok           = noise ? 1'($urandom()) : ($urandom_range(0, 99) >= 8);
        tick.sim_ok             = noise ? 1'($urandom()) : ($urandom_range(0, 99) >= 8);
        tick.net_registered     = noise ? 1'($urandom()) : ($urandom_range(0, 99) < 35);
        tick.data_enable_ok     = noise ? 1'($urandom()) : ($urandom_range(0, 99) >= 10);
        tick.signal_sample      = 8'($urandom());
        tick.data_active_sample = 1'($urandom());
        return tick;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: value};
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk) cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(logic gprs, logic [15:0] settle, logic [15:0] key_pulse,
                              logic [15:0] rst_pulse, logic [15:0] reg_timeout,
                              logic [15:0] poll, logic [1:0] tries);
        write_reg(CFG_GPRS_WANTED, {15'd0, gprs});
        write_reg(CFG_SETTLE_WAIT, settle);
        write_reg(CFG_POWER_PULSE, key_pulse);
        write_reg(CFG_RESET_PULSE, rst_pulse);
        write_reg(CFG_REG_TIMEOUT, reg_timeout);
        write_reg(CFG_POLL_INTERVAL, poll);
        write_reg(CFG_MAX_POWER_TRIES, {14'd0, tries});
    endtask

    // Let every predicted result come back before touching the registers.
    task automatic drain();
        @(negedge i_clk) in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        send_burst   = 0;
        step_max     = 3000;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed walk under the reset settings: disabled start, a retried
        // power pulse, reset pulse, start, SIM, registration, battery, then
        // every poll slot, a forced idle and a time near the wrap point.
        send_flags(32'd0,     7'b0000000, 8'sh80, 1'b0);
        send_flags(32'd1,     7'b1111111, 8'sh7F, 1'b1);
        send_flags(32'd2500,  7'b1111111, 8'sh00, 1'b0);
        send_flags(32'd2501,  7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd4501,  7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd7001,  7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd7002,  7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd9002,  7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd11502, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd11503, 7'b1010000, 8'sh00, 1'b0);
        send_flags(32'd11603, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd14103, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd14104, 7'b1001000, 8'sh00, 1'b0);
        send_flags(32'd16604, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd16605, 7'b1000100, 8'sh00, 1'b0);
        send_flags(32'd16700, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd16800, 7'b1000010, 8'sh00, 1'b0);
        send_flags(32'd19300, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd19301, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd21301, 7'b1000000, 8'sh80, 1'b0);
        send_flags(32'd23301, 7'b1000000, 8'sh00, 1'b1);
        send_flags(32'd25301, 7'b1000000, 8'sh00, 1'b0);
        send_flags(32'd27301, 7'b1000000, 8'sh7F, 1'b0);
        send_flags(32'd27302, 7'b0000000, 8'sh00, 1'b0);
        send_flags(32'hFFFF_FFFF, 7'b1111111, 8'shFF, 1'b1);
        now_cursor = 32'hFFFF_FFFF;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) drain();
            case (p)
                0: step_max = 3000;
                1: begin
                    set_config(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
                    step_max = 40;
                end
                2: begin
                    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
                    step_max = 40000;
                end
                3: begin
                    set_config(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 2'd1);
                    write_reg(CFG_UNUSED_IDX, 16'($urandom()));
                    step_max = 3;
                end
                default: begin
                    set_config(1'($urandom()), 16'($urandom_range(0, 60)),
                               16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                               16'($urandom_range(0, 300)), 16'($urandom_range(0, 60)),
                               2'($urandom_range(0, 3)));
                    step_max = 40;
                end
            endcase
            repeat (TICKS_PER_PHASE) send_tick(random_tick());
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
